[hdl/dts_pkg.sv]
// Shared types and constants for the dependency ordering unit.
package dts_pkg;
    localparam int MaxPasses    = 32;
    localparam int NumResources = 32;
    localparam int WriteSlots   = 4;
    localparam int ResW         = 6;
    localparam int MaskW        = 32;

    typedef struct packed {
        logic [MaskW-1:0] read_mask;
        logic [ResW-1:0]  wr0;
        logic [ResW-1:0]  wr1;
        logic [ResW-1:0]  wr2;
        logic [ResW-1:0]  wr3;
        logic             last_pass;
    } t_item;

    typedef enum logic [2:0] {
        S_LOAD, S_DEG, S_SEED, S_POP, S_EMIT, S_SCAN, S_STATUS
    } t_state;
endpackage

[hdl/dependency_topological_sort_unit.sv]
// Top level of the dependency ordering unit.
// Each input word loads one pass, at most MAX_PASSES in all; the word marked
// last_pass starts a sort that counts in-degrees, seeds the stack with the
// passes of in-degree zero and emits the passes one by one, then a status
// word. A single comparator walks one pass, slot pair per cycle. Input is not
// taken during a sort beyond the two word front queue.
module dependency_topological_sort_unit #(
    parameter int MAX_PASSES    = dts_pkg::MaxPasses,
    parameter int NUM_RESOURCES = dts_pkg::NumResources,
    parameter int WRITE_SLOTS   = dts_pkg::WriteSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_read_mask,
    input  logic [5:0]  i_write_res_0,
    input  logic [5:0]  i_write_res_1,
    input  logic [5:0]  i_write_res_2,
    input  logic [5:0]  i_write_res_3,
    input  logic        i_last_pass,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_pass_index,
    output logic        o_is_status,
    output logic        o_cycle_found,
    output logic [5:0]  o_ordered_count,
    output logic        o_last
);
    import dts_pkg::*;
    t_item in_item, q_item;
    logic q_valid, q_ready;

    assign in_item = '{read_mask: i_read_mask, wr0: i_write_res_0, wr1: i_write_res_1,
                       wr2: i_write_res_2, wr3: i_write_res_3, last_pass: i_last_pass};

    dts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(in_item), .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    dts_back #(
        .MAX_PASSES(MAX_PASSES), .NUM_RESOURCES(NUM_RESOURCES), .WRITE_SLOTS(WRITE_SLOTS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_item(q_item), .o_valid(o_valid), .i_ready(i_ready),
        .o_pass_index(o_pass_index), .o_is_status(o_is_status),
        .o_cycle_found(o_cycle_found), .o_ordered_count(o_ordered_count), .o_last(o_last)
    );
endmodule

[hdl/dts_front.sv]
// Input stage: accepts words and buffers them in a two entry queue.
module dts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dts_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output dts_pkg::t_item o_item
);
    import dts_pkg::*;
    t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_rd ^ r_cnt[0]] <= i_item;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[hdl/dts_back.sv]
// Sort engine: stores passes, counts in-degrees and runs the stack walk.
module dts_back #(
    parameter int MAX_PASSES    = dts_pkg::MaxPasses,
    parameter int NUM_RESOURCES = dts_pkg::NumResources,
    parameter int WRITE_SLOTS   = dts_pkg::WriteSlots
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dts_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [4:0]     o_pass_index,
    output logic           o_is_status,
    output logic           o_cycle_found,
    output logic [5:0]     o_ordered_count,
    output logic           o_last
);
    import dts_pkg::*;
    localparam int PW = $clog2(MAX_PASSES + 1);
    localparam int IW = $clog2(MAX_PASSES);

    t_state r_st, n_st;
    logic [MaskW-1:0]  r_mask [MAX_PASSES];
    logic [4*ResW-1:0] r_wr   [MAX_PASSES];
    logic [6:0]        r_deg  [MAX_PASSES];
    logic [IW-1:0]     r_stk  [MAX_PASSES];
    logic [PW-1:0] r_n, r_sp, r_emit, r_i, r_j;
    logic [1:0] r_s;
    logic [IW-1:0] r_u;
    logic r_ov;
    logic [4:0] r_opi;
    logic r_ost, r_ocy, r_ol;
    logic [5:0] r_ocnt;

    logic [ResW-1:0] res;
    logic hit, slot_ok, last_s, last_j;
    logic out_load;
    logic [IW-1:0] src;

    assign src = (r_st == S_DEG) ? r_i[IW-1:0] : r_u;
    assign res = r_wr[src][r_s*ResW +: ResW];
    assign slot_ok = ({1'b0, res} < 7'(NUM_RESOURCES)) && (res < ResW'(MaskW));
    assign hit = slot_ok && (r_j[IW-1:0] != src) && r_mask[r_j[IW-1:0]][res[4:0]];
    assign last_j = (r_j == r_n - PW'(1));
    assign last_s = (r_s == 2'(WRITE_SLOTS - 1));
    assign out_load = (!r_ov || i_ready)
                      && ((r_st == S_POP && r_sp != '0) || r_st == S_STATUS);

    assign o_ready = (r_st == S_LOAD);
    assign o_valid = r_ov;
    assign o_pass_index = r_opi;
    assign o_is_status = r_ost;
    assign o_cycle_found = r_ocy;
    assign o_ordered_count = r_ocnt;
    assign o_last = r_ol;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_LOAD: if (i_valid && i_item.last_pass) n_st = S_DEG;
            S_DEG: if (last_j && last_s && r_i == r_n - PW'(1)) n_st = S_SEED;
            S_SEED: if (r_i == r_n - PW'(1)) n_st = S_POP;
            S_POP: if (!r_ov || i_ready) n_st = (r_sp == '0) ? S_STATUS : S_SCAN;
            S_SCAN: if (last_j && last_s) n_st = S_POP;
            S_STATUS: if (!r_ov || i_ready) n_st = S_LOAD;
            default: n_st = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_n <= '0;
            r_ov <= 1'b0;
            r_sp <= '0;
            r_emit <= '0;
        end else begin
            r_st <= n_st;
            if (out_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            case (r_st)
                S_LOAD: begin
                    if (i_valid) begin
                        if (r_n < PW'(MAX_PASSES)) begin
                            r_mask[r_n[IW-1:0]] <= i_item.read_mask;
                            r_wr[r_n[IW-1:0]] <= {i_item.wr3, i_item.wr2,
                                                  i_item.wr1, i_item.wr0};
                            r_n <= r_n + PW'(1);
                        end
                        r_i <= '0; r_j <= '0; r_s <= '0;
                        r_sp <= '0; r_emit <= '0;
                        for (int k = 0; k < MAX_PASSES; k++) r_deg[k] <= '0;
                    end
                end
                S_DEG: begin
                    if (hit) r_deg[r_j[IW-1:0]] <= r_deg[r_j[IW-1:0]] + 7'd1;
                    if (!last_j) r_j <= r_j + PW'(1);
                    else begin
                        r_j <= '0;
                        if (!last_s) r_s <= r_s + 2'd1;
                        else begin
                            r_s <= '0;
                            r_i <= (r_i == r_n - PW'(1)) ? '0 : r_i + PW'(1);
                        end
                    end
                end
                S_SEED: begin
                    if (r_deg[r_i[IW-1:0]] == '0) begin
                        r_stk[r_sp[IW-1:0]] <= r_i[IW-1:0];
                        r_sp <= r_sp + PW'(1);
                    end
                    r_i <= r_i + PW'(1);
                end
                S_POP: begin
                    if ((!r_ov || i_ready) && r_sp != '0) begin
                        r_u <= r_stk[r_sp[IW-1:0] - IW'(1)];
                        r_sp <= r_sp - PW'(1);
                        r_opi <= 5'(r_stk[r_sp[IW-1:0] - IW'(1)]);
                        r_ost <= 1'b0; r_ocy <= 1'b0; r_ocnt <= '0; r_ol <= 1'b0;
                        r_emit <= r_emit + PW'(1);
                        r_j <= '0; r_s <= '0;
                    end
                end
                S_SCAN: begin
                    if (hit && r_deg[r_j[IW-1:0]] != '0) begin
                        r_deg[r_j[IW-1:0]] <= r_deg[r_j[IW-1:0]] - 7'd1;
                        if (r_deg[r_j[IW-1:0]] == 7'd1) begin
                            r_stk[r_sp[IW-1:0]] <= r_j[IW-1:0];
                            r_sp <= r_sp + PW'(1);
                        end
                    end
                    if (!last_j) r_j <= r_j + PW'(1);
                    else begin
                        r_j <= '0;
                        r_s <= r_s + 2'd1;
                    end
                end
                S_STATUS: begin
                    if (!r_ov || i_ready) begin
                        r_opi <= '0; r_ost <= 1'b1; r_ol <= 1'b1;
                        r_ocy <= (r_emit < r_n);
                        r_ocnt <= 6'(r_emit);
                        r_n <= '0; r_sp <= '0; r_emit <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
